// ===== rtl/ttb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the triangle tangent/binormal unit: widths, controller states,
// datapath operation codes and the command/status structs. No dependencies.
package ttb_pkg;

    localparam int WORD_W   = 32;              // Q16.16 input word
    localparam int DELTA_W  = WORD_W + 1;      // difference of two words
    localparam int PROD_W   = 2 * DELTA_W;     // exact product of two deltas
    localparam int CROSS_W  = PROD_W + 1;      // a*b - c*d
    localparam int MAG_W    = PROD_W;          // magnitude of a cross term
    localparam int NORM_TOP = 29;              // normalized top bit position
    localparam int SCALED_W = NORM_TOP + 1;    // normalized magnitude width
    localparam int SUM_W    = 2 * SCALED_W + 2;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int FRAC_W   = 14;              // Q1.14 output fraction bits
    localparam int QUO_W    = 16;
    localparam int NUM_W    = SCALED_W + FRAC_W + 1;
    localparam int OUT_W    = 16;
    localparam int NUM_PRODS = 14;             // two products for each cross term
    localparam int NUM_TERMS = NUM_PRODS / 2;  // det, three tangent, three binormal
    localparam int NUM_HELD  = 10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_MUL,
        ST_CHECK,
        ST_LOAD,
        ST_SHIFT,
        ST_SQUARE,
        ST_ROOT,
        ST_ROOT_WAIT,
        ST_DIV,
        ST_DIV_WAIT,
        ST_WRITE
    } state_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_STORE,
        OP_DELTA,
        OP_MUL,
        OP_LOAD,
        OP_SHIFT,
        OP_SQUARE,
        OP_ROOT,
        OP_DIVIDE,
        OP_KEEP,
        OP_WRITE_OK,
        OP_WRITE_DEGEN
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] slot;
        logic [3:0] k;
        logic       vec;
        logic [1:0] comp;
    } cmd_t;

    typedef struct packed {
        logic det_zero;
        logic vec_zero;
        logic shift_done;
        logic root_done;
        logic div_done;
    } status_t;

endpackage

// ===== rtl/ttb_in_if.sv =====
`timescale 1ns / 1ps
// Vertex channel interface: valid/ready handshake with one vertex payload.
// Depends on ttb_pkg for the word width.
interface ttb_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [ttb_pkg::WORD_W-1:0] pos_x;
    logic signed [ttb_pkg::WORD_W-1:0] pos_y;
    logic signed [ttb_pkg::WORD_W-1:0] pos_z;
    logic signed [ttb_pkg::WORD_W-1:0] tex_u;
    logic signed [ttb_pkg::WORD_W-1:0] tex_v;
    logic                             first_of_model;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, first_of_model,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, first_of_model,
                  output ready);
endinterface

// ===== rtl/ttb_out_if.sv =====
`timescale 1ns / 1ps
// Result channel interface: valid/ready handshake with one face result.
// Depends on ttb_pkg for the output width.
interface ttb_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [ttb_pkg::OUT_W-1:0] tangent_x;
    logic signed [ttb_pkg::OUT_W-1:0] tangent_y;
    logic signed [ttb_pkg::OUT_W-1:0] tangent_z;
    logic signed [ttb_pkg::OUT_W-1:0] binormal_x;
    logic signed [ttb_pkg::OUT_W-1:0] binormal_y;
    logic signed [ttb_pkg::OUT_W-1:0] binormal_z;
    logic                            degenerate;

    modport source (output valid, tangent_x, tangent_y, tangent_z, binormal_x,
                    binormal_y, binormal_z, degenerate, input ready);
    modport sink (input valid, tangent_x, tangent_y, tangent_z, binormal_x,
                  binormal_y, binormal_z, degenerate, output ready);
endinterface

// ===== rtl/ttb_isqrt.sv =====
`timescale 1ns / 1ps
// Iterative integer square root, two radicand bits per cycle.
// Depends on ttb_pkg for widths.
module ttb_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ttb_pkg::SUM_W-1:0]   radicand,
    output logic [ttb_pkg::ROOT_W-1:0]  root,
    output logic                        done
);
    localparam int REM_W = ttb_pkg::ROOT_W + 3;
    localparam int CNT_W = $clog2(ttb_pkg::ROOT_W + 1);

    logic [ttb_pkg::SUM_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [ttb_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [REM_W+1:0]           rem_sh;
    logic [REM_W+1:0]           trial;

    // One result bit per cycle: bring down two bits and try the subtraction.
    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, rad_reg[ttb_pkg::SUM_W-1 -: 2]};
        trial     = {{(REM_W - ttb_pkg::ROOT_W){1'b0}}, root_reg, 2'b01};
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[ttb_pkg::SUM_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[ttb_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_reg[ttb_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == CNT_W'(ttb_pkg::ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;
endmodule

// ===== rtl/ttb_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the Q1.14 components.
// Depends on ttb_pkg; the quotient is known to fit in QUO_W bits.
module ttb_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ttb_pkg::NUM_W-1:0]   numer,
    input  logic [ttb_pkg::ROOT_W-1:0]  denom,
    output logic [ttb_pkg::QUO_W-1:0]   quot,
    output logic                        done
);
    localparam int REM_W = ttb_pkg::ROOT_W + 1;
    localparam int HI_W  = ttb_pkg::NUM_W - ttb_pkg::QUO_W;
    localparam int CNT_W = $clog2(ttb_pkg::QUO_W + 1);

    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [ttb_pkg::QUO_W-1:0] low_reg, low_next;
    logic [ttb_pkg::QUO_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [REM_W-1:0]          rem_sh;

    // Shift in one numerator bit and subtract the divisor when it fits.
    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[REM_W-2:0], low_reg[ttb_pkg::QUO_W-1]};
        if (start)
        begin
            rem_next  = REM_W'(numer[ttb_pkg::NUM_W-1 -: HI_W]);
            low_next  = numer[ttb_pkg::QUO_W-1:0];
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            low_next = {low_reg[ttb_pkg::QUO_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, denom})
            begin
                rem_next = rem_sh - {1'b0, denom};
                q_next   = {q_reg[ttb_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[ttb_pkg::QUO_W-2:0], 1'b0};
            end
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == CNT_W'(ttb_pkg::QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
    end

    assign quot = q_reg;
    assign done = done_reg;
endmodule

// ===== rtl/ttb_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: held vertices, deltas, shared multiplier, cross terms,
// normalization, square root and divider. Depends on ttb_pkg, ttb_isqrt, ttb_div.
module ttb_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ttb_pkg::cmd_t                     cmd,
    output ttb_pkg::status_t                  status,
    input  logic signed [ttb_pkg::WORD_W-1:0] pos_x,
    input  logic signed [ttb_pkg::WORD_W-1:0] pos_y,
    input  logic signed [ttb_pkg::WORD_W-1:0] pos_z,
    input  logic signed [ttb_pkg::WORD_W-1:0] tex_u,
    input  logic signed [ttb_pkg::WORD_W-1:0] tex_v,
    output logic signed [ttb_pkg::OUT_W-1:0]  tangent_x,
    output logic signed [ttb_pkg::OUT_W-1:0]  tangent_y,
    output logic signed [ttb_pkg::OUT_W-1:0]  tangent_z,
    output logic signed [ttb_pkg::OUT_W-1:0]  binormal_x,
    output logic signed [ttb_pkg::OUT_W-1:0]  binormal_y,
    output logic signed [ttb_pkg::OUT_W-1:0]  binormal_z,
    output logic                              degenerate
);
    localparam int WW = ttb_pkg::WORD_W;
    localparam int DW = ttb_pkg::DELTA_W;
    localparam int PW = ttb_pkg::PROD_W;
    localparam int CW = ttb_pkg::CROSS_W;
    localparam int MW = ttb_pkg::MAG_W;
    localparam int SW = ttb_pkg::SCALED_W;
    localparam int TOP = ttb_pkg::NORM_TOP;
    localparam int OW = ttb_pkg::OUT_W;

    logic [WW-1:0]        held_reg [ttb_pkg::NUM_HELD];
    logic [WW-1:0]        p3_reg [5];
    logic signed [DW-1:0] e1_reg [3];
    logic signed [DW-1:0] e2_reg [3];
    logic signed [DW-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [PW-1:0] prod_reg, acc_reg;
    logic [3:0]           pidx_reg;
    logic                 pv_reg, psq_reg;
    logic signed [CW-1:0] cr_reg [ttb_pkg::NUM_TERMS];
    logic [MW-1:0]        m_reg [3];
    logic                 sgn_reg [3];
    logic [ttb_pkg::SUM_W-1:0] sum_reg;
    logic signed [OW-1:0] tq_reg [3];
    logic signed [OW-1:0] bq_reg [3];
    logic signed [OW-1:0] out_t_reg [3];
    logic signed [OW-1:0] out_b_reg [3];
    logic                 degen_reg;

    logic signed [DW-1:0] op_a, op_b;
    logic [MW-1:0]        or_all;
    logic [SW-1:0]        s_sel;
    logic                 sgn_sel;
    logic [ttb_pkg::ROOT_W-1:0] root;
    logic                 root_done;
    logic [ttb_pkg::QUO_W-1:0]  quot;
    logic                 div_done;
    logic [ttb_pkg::NUM_W-1:0]  numer;
    logic [OW-1:0]        q_signed;
    logic [WW-1:0]        in_word [5];

    assign in_word[0] = pos_x;
    assign in_word[1] = pos_y;
    assign in_word[2] = pos_z;
    assign in_word[3] = tex_u;
    assign in_word[4] = tex_v;

    // Multiplier operand selection for the cross terms and the squares.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (cmd.op == ttb_pkg::OP_SQUARE)
        begin
            op_a = DW'(s_sel);
            op_b = DW'(s_sel);
        end
        else
        begin
            case (cmd.k)
                4'd0:    begin op_a = du1_reg; op_b = dv2_reg;   end
                4'd1:    begin op_a = du2_reg; op_b = dv1_reg;   end
                4'd2:    begin op_a = dv2_reg; op_b = e1_reg[0]; end
                4'd3:    begin op_a = dv1_reg; op_b = e2_reg[0]; end
                4'd4:    begin op_a = dv2_reg; op_b = e1_reg[1]; end
                4'd5:    begin op_a = dv1_reg; op_b = e2_reg[1]; end
                4'd6:    begin op_a = dv2_reg; op_b = e1_reg[2]; end
                4'd7:    begin op_a = dv1_reg; op_b = e2_reg[2]; end
                4'd8:    begin op_a = du1_reg; op_b = e2_reg[0]; end
                4'd9:    begin op_a = du2_reg; op_b = e1_reg[0]; end
                4'd10:   begin op_a = du1_reg; op_b = e2_reg[1]; end
                4'd11:   begin op_a = du2_reg; op_b = e1_reg[1]; end
                4'd12:   begin op_a = du1_reg; op_b = e2_reg[2]; end
                4'd13:   begin op_a = du2_reg; op_b = e1_reg[2]; end
                default: begin op_a = '0;      op_b = '0;        end
            endcase
        end
    end

    // Component selection for squaring (by k) and dividing (by comp).
    always_comb
    begin
        logic [1:0] idx;
        idx = (cmd.op == ttb_pkg::OP_SQUARE) ? cmd.k[1:0] : cmd.comp;
        case (idx)
            2'd0:    begin s_sel = m_reg[0][SW-1:0]; sgn_sel = sgn_reg[0]; end
            2'd1:    begin s_sel = m_reg[1][SW-1:0]; sgn_sel = sgn_reg[1]; end
            2'd2:    begin s_sel = m_reg[2][SW-1:0]; sgn_sel = sgn_reg[2]; end
            default: begin s_sel = '0;               sgn_sel = 1'b0;       end
        endcase
    end

    assign or_all = m_reg[0] | m_reg[1] | m_reg[2];
    assign numer  = {1'b0, s_sel, {ttb_pkg::FRAC_W{1'b0}}}
                  + ttb_pkg::NUM_W'(root[ttb_pkg::ROOT_W-1:1]);
    assign q_signed = sgn_sel ? OW'(-quot) : OW'(quot);

    // Product pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg  <= 1'b0;
            psq_reg <= 1'b0;
        end
        else
        begin
            pv_reg  <= (cmd.op == ttb_pkg::OP_MUL) && (cmd.k < 4'(ttb_pkg::NUM_PRODS));
            psq_reg <= (cmd.op == ttb_pkg::OP_SQUARE) && (cmd.k < 4'd3);
        end
    end

    // Payload registers driven by the command.
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        pidx_reg <= cmd.k;

        // Cross term accumulation: even product starts, odd product subtracts.
        if (pv_reg)
        begin
            if (!pidx_reg[0])
                acc_reg <= prod_reg;
            else
                cr_reg[pidx_reg[3:1]] <= CW'(acc_reg) - CW'(prod_reg);
        end
        if (psq_reg)
            sum_reg <= sum_reg + ttb_pkg::SUM_W'(prod_reg);

        unique case (cmd.op)
            ttb_pkg::OP_STORE:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    if (cmd.slot == 2'd0)
                        held_reg[i] <= in_word[i];
                    else if (cmd.slot == 2'd1)
                        held_reg[5 + i] <= in_word[i];
                    else
                        p3_reg[i] <= in_word[i];
                end
            end
            ttb_pkg::OP_DELTA:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1_reg[i] <= DW'($signed(held_reg[5 + i])) - DW'($signed(held_reg[i]));
                    e2_reg[i] <= DW'($signed(p3_reg[i])) - DW'($signed(held_reg[i]));
                end
                du1_reg <= DW'($signed(held_reg[8])) - DW'($signed(held_reg[3]));
                dv1_reg <= DW'($signed(held_reg[9])) - DW'($signed(held_reg[4]));
                du2_reg <= DW'($signed(p3_reg[3])) - DW'($signed(held_reg[3]));
                dv2_reg <= DW'($signed(p3_reg[4])) - DW'($signed(held_reg[4]));
            end
            ttb_pkg::OP_LOAD:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    logic signed [CW-1:0] v;
                    logic [CW-1:0]        mag;
                    v = cmd.vec ? cr_reg[4 + c] : cr_reg[1 + c];
                    mag = v[CW-1] ? CW'(-v) : CW'(v);
                    m_reg[c]   <= mag[MW-1:0];
                    sgn_reg[c] <= v[CW-1] ^ cr_reg[0][CW-1];
                end
                sum_reg <= '0;
            end
            ttb_pkg::OP_SHIFT:
            begin
                // Coarse then fine steps bring the top set bit to NORM_TOP.
                for (int c = 0; c < 3; c++)
                begin
                    if (|or_all[MW-1:TOP+8])
                        m_reg[c] <= m_reg[c] >> 8;
                    else if (|or_all[MW-1:TOP+1])
                        m_reg[c] <= m_reg[c] >> 1;
                    else if (~|or_all[TOP:TOP-7])
                        m_reg[c] <= m_reg[c] << 8;
                    else if (!or_all[TOP])
                        m_reg[c] <= m_reg[c] << 1;
                end
            end
            ttb_pkg::OP_KEEP:
            begin
                if (!cmd.vec)
                    tq_reg[cmd.comp] <= q_signed;
                else
                    bq_reg[cmd.comp] <= q_signed;
            end
            ttb_pkg::OP_WRITE_OK:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    out_t_reg[c] <= tq_reg[c];
                    out_b_reg[c] <= bq_reg[c];
                end
                degen_reg <= 1'b0;
            end
            ttb_pkg::OP_WRITE_DEGEN:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    out_t_reg[c] <= '0;
                    out_b_reg[c] <= '0;
                end
                degen_reg <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    ttb_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == ttb_pkg::OP_ROOT),
        .radicand (sum_reg),
        .root     (root),
        .done     (root_done)
    );

    ttb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == ttb_pkg::OP_DIVIDE),
        .numer (numer),
        .denom (root),
        .quot  (quot),
        .done  (div_done)
    );

    assign status.det_zero   = (cr_reg[0] == '0);
    assign status.vec_zero   = (or_all == '0);
    assign status.shift_done = (~|or_all[MW-1:TOP+1]) && or_all[TOP];
    assign status.root_done  = root_done;
    assign status.div_done   = div_done;

    assign tangent_x  = out_t_reg[0];
    assign tangent_y  = out_t_reg[1];
    assign tangent_z  = out_t_reg[2];
    assign binormal_x = out_b_reg[0];
    assign binormal_y = out_b_reg[1];
    assign binormal_z = out_b_reg[2];
    assign degenerate = degen_reg;
endmodule

// ===== rtl/ttb_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: vertex slot tracking, the per-triangle sequence and output valid.
// Depends on ttb_pkg for states, operation codes and command/status structs.
module ttb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              first_of_model,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output ttb_pkg::cmd_t     cmd,
    input  ttb_pkg::status_t  status
);
    ttb_pkg::state_t state_reg, state_next;
    logic [1:0] slot_reg, slot_next;
    logic [3:0] k_reg, k_next;
    logic       vec_reg, vec_next;
    logic [1:0] comp_reg, comp_next;
    logic       degen_reg, degen_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] slot_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttb_pkg::ST_IDLE;
            slot_reg      <= '0;
            k_reg         <= '0;
            vec_reg       <= 1'b0;
            comp_reg      <= '0;
            degen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            k_reg         <= k_next;
            vec_reg       <= vec_next;
            comp_reg      <= comp_next;
            degen_reg     <= degen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign slot_eff = first_of_model ? 2'd0 : slot_reg;

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        k_next         = k_reg;
        vec_next       = vec_reg;
        comp_next      = comp_reg;
        degen_next     = degen_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = ttb_pkg::OP_IDLE;
        cmd.slot       = slot_eff;
        cmd.k          = k_reg;
        cmd.vec        = vec_reg;
        cmd.comp       = comp_reg;

        unique case (state_reg)
            ttb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = ttb_pkg::OP_STORE;
                    if (slot_eff == 2'd2)
                    begin
                        slot_next  = 2'd0;
                        state_next = ttb_pkg::ST_DELTA;
                    end
                    else
                        slot_next = slot_eff + 2'd1;
                end
            end
            ttb_pkg::ST_DELTA:
            begin
                cmd.op     = ttb_pkg::OP_DELTA;
                k_next     = '0;
                state_next = ttb_pkg::ST_MUL;
            end
            ttb_pkg::ST_MUL:
            begin
                // The count runs to NUM_PRODS, past the last product, so that the last product reaches its cross term.
                cmd.op = ttb_pkg::OP_MUL;
                k_next = k_reg + 4'd1;
                if (k_reg == 4'(ttb_pkg::NUM_PRODS))
                    state_next = ttb_pkg::ST_CHECK;
            end
            ttb_pkg::ST_CHECK:
            begin
                vec_next = 1'b0;
                if (status.det_zero)
                begin
                    degen_next = 1'b1;
                    state_next = ttb_pkg::ST_WRITE;
                end
                else
                    state_next = ttb_pkg::ST_LOAD;
            end
            ttb_pkg::ST_LOAD:
            begin
                cmd.op     = ttb_pkg::OP_LOAD;
                state_next = ttb_pkg::ST_SHIFT;
            end
            ttb_pkg::ST_SHIFT:
            begin
                k_next = '0;
                if (status.vec_zero)
                begin
                    degen_next = 1'b1;
                    state_next = ttb_pkg::ST_WRITE;
                end
                else if (status.shift_done)
                    state_next = ttb_pkg::ST_SQUARE;
                else
                    cmd.op = ttb_pkg::OP_SHIFT;
            end
            ttb_pkg::ST_SQUARE:
            begin
                cmd.op = ttb_pkg::OP_SQUARE;
                k_next = k_reg + 4'd1;
                if (k_reg == 4'd3)
                    state_next = ttb_pkg::ST_ROOT;
            end
            ttb_pkg::ST_ROOT:
            begin
                cmd.op     = ttb_pkg::OP_ROOT;
                state_next = ttb_pkg::ST_ROOT_WAIT;
            end
            ttb_pkg::ST_ROOT_WAIT:
            begin
                comp_next = '0;
                if (status.root_done)
                    state_next = ttb_pkg::ST_DIV;
            end
            ttb_pkg::ST_DIV:
            begin
                cmd.op     = ttb_pkg::OP_DIVIDE;
                state_next = ttb_pkg::ST_DIV_WAIT;
            end
            ttb_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op = ttb_pkg::OP_KEEP;
                    if (comp_reg == 2'd2)
                    begin
                        if (!vec_reg)
                        begin
                            vec_next   = 1'b1;
                            state_next = ttb_pkg::ST_LOAD;
                        end
                        else
                        begin
                            degen_next = 1'b0;
                            state_next = ttb_pkg::ST_WRITE;
                        end
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ttb_pkg::ST_DIV;
                    end
                end
            end
            ttb_pkg::ST_WRITE:
            begin
                // Wait until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op = degen_reg ? ttb_pkg::OP_WRITE_DEGEN : ttb_pkg::OP_WRITE_OK;
                    out_valid_next = 1'b1;
                    degen_next     = 1'b0;
                    state_next     = ttb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ttb_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
endmodule

// ===== rtl/triangle_tangent_binormal_unit.sv =====
`timescale 1ns / 1ps
// Top level of the triangle tangent/binormal unit.
// Depends on ttb_pkg, ttb_in_if, ttb_out_if, ttb_ctrl and ttb_datapath.
//
// Vertices arrive one per transfer, three to a triangle; first_of_model
// restarts the grouping. The first two vertices of a triangle are just stored.
// The third starts a computation: a delta step, the products on the shared
// 33x33 multiplier for the determinant and the six cross terms, a check
// step, then for each of the two vectors a load, a normalizing shift in
// coarse and fine steps, the squaring of the three components, an iterative
// square root and three iterative divisions. The square root and divider are
// the dominant units. A zero determinant, or a zero tangent or binormal, ends
// with zero vectors and the degenerate flag. The finished result sits in an
// output register, and vertices of the next triangle are taken while it
// waits for its transfer.
module triangle_tangent_binormal_unit (
    input  logic     clk,
    input  logic     rst_n,
    ttb_in_if.sink   vtx,
    ttb_out_if.source res
);
    ttb_pkg::cmd_t    cmd;
    ttb_pkg::status_t status;

    ttb_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (vtx.valid),
        .first_of_model (vtx.first_of_model),
        .in_ready       (vtx.ready),
        .out_valid      (res.valid),
        .out_ready      (res.ready),
        .cmd            (cmd),
        .status         (status)
    );

    ttb_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .pos_x      (vtx.pos_x),
        .pos_y      (vtx.pos_y),
        .pos_z      (vtx.pos_z),
        .tex_u      (vtx.tex_u),
        .tex_v      (vtx.tex_v),
        .tangent_x  (res.tangent_x),
        .tangent_y  (res.tangent_y),
        .tangent_z  (res.tangent_z),
        .binormal_x (res.binormal_x),
        .binormal_y (res.binormal_y),
        .binormal_z (res.binormal_z),
        .degenerate (res.degenerate)
    );
endmodule

// ===== rtl/ttb_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the triangle tangent/binormal unit, bound to the top.
// Depends on ttb_pkg for widths.
module ttb_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [ttb_pkg::OUT_W-1:0] tangent_x,
    input logic signed [ttb_pkg::OUT_W-1:0] tangent_y,
    input logic signed [ttb_pkg::OUT_W-1:0] tangent_z,
    input logic signed [ttb_pkg::OUT_W-1:0] binormal_x,
    input logic signed [ttb_pkg::OUT_W-1:0] binormal_y,
    input logic signed [ttb_pkg::OUT_W-1:0] binormal_z,
    input logic                             degenerate
);
    localparam logic signed [ttb_pkg::OUT_W-1:0] ONE = 16'sd16384;

    // A stalled result stays valid and keeps its tangent_x, binormal_z and degenerate fields.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tangent_x)
            && $stable(binormal_z) && $stable(degenerate))
        else $error("result changed while stalled");

    // A degenerate face reports zero vectors.
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> tangent_x == 0 && tangent_y == 0
            && tangent_z == 0 && binormal_x == 0 && binormal_y == 0 && binormal_z == 0)
        else $error("degenerate result with nonzero vectors");

    // Unit components never exceed one in magnitude.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |-> tangent_x <= ONE && tangent_x >= -ONE
            && tangent_y <= ONE && tangent_y >= -ONE && tangent_z <= ONE
            && tangent_z >= -ONE && binormal_x <= ONE && binormal_x >= -ONE
            && binormal_y <= ONE && binormal_y >= -ONE && binormal_z <= ONE
            && binormal_z >= -ONE)
        else $error("unit component out of range");

    // A new result never appears right after a vertex transfer.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result raised directly after a vertex transfer");
endmodule

bind triangle_tangent_binormal_unit ttb_checker u_ttb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (vtx.valid),
    .in_ready   (vtx.ready),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .tangent_x  (res.tangent_x),
    .tangent_y  (res.tangent_y),
    .tangent_z  (res.tangent_z),
    .binormal_x (res.binormal_x),
    .binormal_y (res.binormal_y),
    .binormal_z (res.binormal_z),
    .degenerate (res.degenerate)
);

// ===== dv/tangent_frame_checker.sv =====
`timescale 1ns / 1ps
// Checker for the triangle tangent/binormal unit: watches both channels,
// predicts each face result and compares it. Depends on ttb_pkg and the
// channel interfaces.
module tangent_frame_checker (
    input  logic     clk,
    input  logic     rst_n,
    ttb_in_if        vtx,
    ttb_out_if       res,
    output int       fail_count,
    output int       pending_faces
);
    localparam int OUT_W    = ttb_pkg::OUT_W;
    localparam int WORD_W   = ttb_pkg::WORD_W;
    localparam int NUM_HELD = ttb_pkg::NUM_HELD;
    localparam int NORM_TOP = ttb_pkg::NORM_TOP;

    typedef struct {
        logic [OUT_W-1:0] tx, ty, tz, bx, by, bz;
        logic             degen;
    } face_t;

    face_t             face_queue[$];
    logic [WORD_W-1:0] held_words[NUM_HELD];
    logic [1:0]        next_slot;

    // Integer square root, floor.
    function automatic logic [63:0] floor_root(input logic [63:0] n);
        logic [63:0] rem, r, b;
        rem = n;
        r = 0;
        b = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Scale a vector to unit length in Q1.14; returns 0 for the zero vector.
    function automatic logic unit_vector(input logic signed [127:0] v0, v1, v2,
                                         output logic [OUT_W-1:0] o0, o1, o2);
        logic signed [127:0] v[3];
        logic [127:0]        m[3];
        logic [127:0]        any_bits;
        logic [63:0]         s[3];
        logic [63:0]         sum, len, q;
        logic [OUT_W-1:0]    o[3];
        int                  top;
        v[0] = v0;
        v[1] = v1;
        v[2] = v2;
        any_bits = 0;
        sum = 0;
        top = -1;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            any_bits |= m[i];
        end
        if (any_bits == 0)
            return 1'b0;
        for (int i = 127; i >= 0; i--)
            if (top < 0 && any_bits[i]) top = i;
        for (int i = 0; i < 3; i++)
        begin
            if (top > NORM_TOP)
                s[i] = 64'(m[i] >> (top - NORM_TOP));
            else
                s[i] = 64'(m[i] << (NORM_TOP - top));
            sum += s[i] * s[i];
        end
        len = floor_root(sum);
        if (len == 0)
            return 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            q = (s[i] * 64'd16384 + (len >> 1)) / len;
            if (q > 64'd16384) q = 64'd16384;
            o[i] = (v[i] < 0) ? OUT_W'(-q) : OUT_W'(q);
        end
        o0 = o[0];
        o1 = o[1];
        o2 = o[2];
        return 1'b1;
    endfunction

    // Face result from the two held vertices and the closing vertex.
    function automatic face_t face_frame(input logic [WORD_W-1:0] w3[5]);
        logic signed [127:0] p1[5], p2[5], p3[5], e1[3], e2[3];
        logic signed [127:0] du1, dv1, du2, dv2, det, t[3], b[3];
        face_t               f;
        logic                ok;
        for (int i = 0; i < 5; i++)
        begin
            p1[i] = 128'(signed'(held_words[i]));
            p2[i] = 128'(signed'(held_words[5 + i]));
            p3[i] = 128'(signed'(w3[i]));
        end
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = p2[i] - p1[i];
            e2[i] = p3[i] - p1[i];
        end
        du1 = p2[3] - p1[3];
        dv1 = p2[4] - p1[4];
        du2 = p3[3] - p1[3];
        dv2 = p3[4] - p1[4];
        det = du1 * dv2 - du2 * dv1;
        f = '{default: '0};
        ok = (det != 0);
        if (ok)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t[i] = dv2 * e1[i] - dv1 * e2[i];
                b[i] = du1 * e2[i] - du2 * e1[i];
                if (det < 0)
                begin
                    t[i] = -t[i];
                    b[i] = -b[i];
                end
            end
            ok = unit_vector(t[0], t[1], t[2], f.tx, f.ty, f.tz);
            if (ok)
                ok = unit_vector(b[0], b[1], b[2], f.bx, f.by, f.bz);
        end
        if (!ok)
            f = '{default: '0};
        f.degen = !ok;
        return f;
    endfunction

    // Report one field mismatch.
    function automatic int field_diff(input string name, input logic [OUT_W-1:0] want,
                                      input logic [OUT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
                     $signed(want), $signed(got));
            return 1;
        end
        return 0;
    endfunction

    assign pending_faces = face_queue.size();

    // Track vertex transfers and predict a face on each closing vertex.
    always @(posedge clk or negedge rst_n)
    begin
        logic [WORD_W-1:0] w[5];
        logic [1:0]        slot;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_HELD; i++) held_words[i] <= '0;
            next_slot <= '0;
        end
        else if (vtx.valid && vtx.ready)
        begin
            w[0] = vtx.pos_x;
            w[1] = vtx.pos_y;
            w[2] = vtx.pos_z;
            w[3] = vtx.tex_u;
            w[4] = vtx.tex_v;
            slot = vtx.first_of_model ? 2'd0 : next_slot;
            if (slot < 2)
            begin
                for (int i = 0; i < 5; i++) held_words[slot * 5 + i] <= w[i];
                next_slot <= slot + 2'd1;
            end
            else
            begin
                face_queue.push_back(face_frame(w));
                next_slot <= 2'd0;
            end
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        face_t f;
        int    bad;
        if (!rst_n)
            fail_count <= 0;
        else if (res.valid && res.ready)
        begin
            if (face_queue.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual tx=%0d degen=%0b",
                         $time, res.tangent_x, res.degenerate);
                fail_count <= fail_count + 1;
            end
            else
            begin
                f = face_queue.pop_front();
                bad = field_diff("tangent_x", f.tx, res.tangent_x)
                    + field_diff("tangent_y", f.ty, res.tangent_y)
                    + field_diff("tangent_z", f.tz, res.tangent_z)
                    + field_diff("binormal_x", f.bx, res.binormal_x)
                    + field_diff("binormal_y", f.by, res.binormal_y)
                    + field_diff("binormal_z", f.bz, res.binormal_z)
                    + field_diff("degenerate", OUT_W'(f.degen), OUT_W'(res.degenerate));
                if (bad != 0)
                    fail_count <= fail_count + 1;
            end
        end
    end
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top for the triangle tangent/binormal unit: clock, reset, vertex
// stimulus, result back-pressure and the verdict. Depends on ttb_pkg, the
// channel interfaces, the unit and tangent_frame_checker.
module testbench;
    localparam int WORD_W         = ttb_pkg::WORD_W;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 2000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_faces;
    int   phase;
    int   send_idle;
    int   recv_stall;
    int   hold_cnt;
    bit   hold_done;
    int   quiet_cycles;
    logic [WORD_W-1:0] last_u, last_v;

    ttb_in_if  vtx_ch();
    ttb_out_if res_ch();

    triangle_tangent_binormal_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .vtx   (vtx_ch.sink),
        .res   (res_ch.source)
    );

    tangent_frame_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .vtx           (vtx_ch),
        .res           (res_ch),
        .fail_count    (fail_count),
        .pending_faces (pending_faces)
    );

    always #5 clk = ~clk;

    // Offer one vertex and hold it until the transfer happens.
    task automatic send_vertex(input logic [WORD_W-1:0] x, y, z, u, v, input logic f);
        logic r;
        if ($urandom_range(99) < send_idle)
        begin
            vtx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        vtx_ch.pos_x          <= x;
        vtx_ch.pos_y          <= y;
        vtx_ch.pos_z          <= z;
        vtx_ch.tex_u          <= u;
        vtx_ch.tex_v          <= v;
        vtx_ch.first_of_model <= f;
        vtx_ch.valid          <= 1'b1;
        last_u = u;
        last_v = v;
        forever
        begin
            @(negedge clk);
            r = vtx_ch.ready;
            @(posedge clk);
            if (r) break;
        end
    endtask

    // Random coordinate: mostly small, some full range, some extremes.
    function automatic logic [WORD_W-1:0] coord_word();
        int pick;
        pick = $urandom_range(9);
        if (pick <= 5)
            return WORD_W'($urandom_range(2 ** 21) - 2 ** 20);
        else if (pick <= 8)
            return $urandom;
        case ($urandom_range(3))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // Result-side back-pressure, with one long hold-off early in phase one.
    always @(posedge clk)
    begin
        if (phase == 1 && !hold_done)
        begin
            hold_done = 1'b1;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt = hold_cnt - 1;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((vtx_ch.valid && vtx_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [WORD_W-1:0] w[5];
        logic              f;
        clk = 1'b0;
        rst_n = 1'b0;
        phase = 0;
        send_idle = 0;
        recv_stall = 0;
        hold_cnt = 0;
        hold_done = 1'b0;
        quiet_cycles = 0;
        vtx_ch.valid = 1'b0;
        vtx_ch.pos_x = '0;
        vtx_ch.pos_y = '0;
        vtx_ch.pos_z = '0;
        vtx_ch.tex_u = '0;
        vtx_ch.tex_v = '0;
        vtx_ch.first_of_model = 1'b0;
        res_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a plain right triangle with unit texture mapping.
        send_vertex(0, 0, 0, 0, 0, 1'b1);
        send_vertex(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 1'b0);
        send_vertex(0, 32'h0001_0000, 0, 0, 32'h0001_0000, 1'b0);
        // Mirrored texture: negative determinant.
        send_vertex(0, 0, 0, 0, 0, 1'b0);
        send_vertex(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 1'b0);
        send_vertex(0, 32'h0001_0000, 0, 32'h0001_0000, 0, 1'b0);
        // Zero determinant: all texture coordinates equal.
        send_vertex(5, 6, 7, 32'h1234, 32'h1234, 1'b0);
        send_vertex(9, 2, 3, 32'h1234, 32'h1234, 1'b0);
        send_vertex(1, 8, 4, 32'h1234, 32'h1234, 1'b0);
        // Zero tangent and binormal: all positions equal.
        send_vertex(3, 3, 3, 0, 0, 1'b0);
        send_vertex(3, 3, 3, 32'h0001_0000, 0, 1'b0);
        send_vertex(3, 3, 3, 0, 32'h0001_0000, 1'b0);
        // Extremes of the coordinates.
        send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                    32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                    32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 1'b0);
        // Restart mid-triangle drops the partial one.
        send_vertex(32'hffff_ffff, 1, 2, 3, 4, 1'b0);
        send_vertex(32'h0000_0100, 32'h0000_0200, 32'hffff_0000, 7, 9, 1'b1);
        send_vertex(32'h0002_0000, 32'hffff_ffff, 32'h0000_0001, 32'h0000_8000, 11, 1'b0);
        send_vertex(32'hfffe_0000, 32'h0003_0000, 32'h0001_0000, 13, 32'h0000_8000, 1'b0);

        // Random triangles through the back-pressure phases.
        for (int t = 0; t < 380; t++)
        begin
            if (t % 95 == 0)
            begin
                phase = t / 95;
                case (phase)
                    0: begin send_idle = 0;  recv_stall = 0;  end
                    1: begin send_idle = 73; recv_stall = 0;  end
                    2: begin send_idle = 0;  recv_stall = 73; end
                    default: begin send_idle = 9; recv_stall = 9; end
                endcase
            end
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 5; i++) w[i] = coord_word();
                // Occasionally repeat texture coordinates to force degenerate faces.
                if (k > 0 && $urandom_range(19) == 0)
                begin
                    w[3] = last_u;
                    w[4] = last_v;
                end
                f = (k == 0) ? ($urandom_range(3) == 0) : ($urandom_range(49) == 0);
                send_vertex(w[0], w[1], w[2], w[3], w[4], f);
            end
        end
        vtx_ch.valid <= 1'b0;

        // Drain, then let the block settle.
        while (pending_faces != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== triangle_tangent_binormal_unit.f =====
rtl/ttb_pkg.sv
rtl/ttb_in_if.sv
rtl/ttb_out_if.sv
rtl/ttb_isqrt.sv
rtl/ttb_div.sv
rtl/ttb_datapath.sv
rtl/ttb_ctrl.sv
rtl/triangle_tangent_binormal_unit.sv
rtl/ttb_checker.sv
dv/tangent_frame_checker.sv
dv/testbench.sv
